// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define DTC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define DTC_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- rtl/core/dtc_pkg.sv -----
// Types, widths and register codes for the depth-to-color projection.
`default_nettype none

package dtc_pkg;

    // Field widths.
    localparam int unsigned COL_W   = 9;
    localparam int unsigned ROW_W   = 9;
    localparam int unsigned DEPTH_W = 16;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned INDEX_W = 24;

    // Depth frame bounds.
    localparam int unsigned DEPTH_COLS = 512;
    localparam int unsigned DEPTH_ROWS = 424;

    localparam logic [DEPTH_W-1:0] DEPTH_INVALID = '1;

    // Configuration.
    localparam int unsigned CFG_W         = 64;
    localparam int unsigned COEF_W        = 32;
    localparam int unsigned NUM_COEF_REGS = 6;
    localparam int unsigned NUM_COEF      = 2 * NUM_COEF_REGS;
    localparam int unsigned COEF_T_BASE   = 9;
    localparam int unsigned REG_IDX_W     = 3;

    localparam logic [COORD_W-1:0] WIDTH_RESET  = 12'd1920;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'd1080;

    // Axes of the projected vector.
    localparam int unsigned NUM_AXES = 3;
    localparam int unsigned AXIS_X   = 0;
    localparam int unsigned AXIS_Y   = 1;
    localparam int unsigned AXIS_Z   = 2;

    // Datapath widths.
    localparam int unsigned PROD_W = COEF_W + COL_W + 1;   // coef * col
    localparam int unsigned SUM_W  = PROD_W + 2;           // row sum of M
    localparam int unsigned SCL_W  = SUM_W + DEPTH_W + 1;  // times depth
    localparam int unsigned V_W    = SCL_W + 1;            // minus t
    localparam int unsigned NUM_W  = V_W + 2;              // 2*v + v2
    localparam int unsigned MAG_W  = NUM_W - 1;            // magnitudes, 2*v2
    localparam int unsigned QUOT_W = COORD_W;

    // Front stages that carry only valid and reject flags.
    localparam int unsigned PROJ_STAGES = 5;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_M00_M01      = 3'd0,
        REG_M02_M10      = 3'd1,
        REG_M11_M12      = 3'd2,
        REG_M20_M21      = 3'd3,
        REG_M22_T0       = 3'd4,
        REG_T1_T2        = 3'd5,
        REG_COLOR_WIDTH  = 3'd6,
        REG_COLOR_HEIGHT = 3'd7
    } cfg_reg_t;

    typedef logic [NUM_COEF_REGS-1:0][CFG_W-1:0] coef_bank_t;

    typedef struct packed {
        logic [COL_W-1:0]   depth_col;
        logic [ROW_W-1:0]   depth_row;
        logic [DEPTH_W-1:0] depth_mm;
    } dtc_in_t;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] color_x;
        logic [COORD_W-1:0] color_y;
        logic [INDEX_W-1:0] color_index;
    } dtc_out_t;

    // Projection front end to divider.
    typedef struct packed {
        logic             valid;
        logic             miss;
        logic             neg_x;
        logic [MAG_W-1:0] mag_x;
        logic             neg_y;
        logic [MAG_W-1:0] mag_y;
        logic [MAG_W-1:0] den;
    } dtc_frac_t;

    // Divider to bounds check.
    typedef struct packed {
        logic              valid;
        logic              miss;
        logic              neg_x;
        logic              ovf_x;
        logic [QUOT_W-1:0] qx;
        logic              neg_y;
        logic              ovf_y;
        logic [QUOT_W-1:0] qy;
    } dtc_quot_t;

endpackage

`default_nettype wire

// ----- rtl/core/dtc_proj.sv -----
// Projection front end: v = M*[col,row,1]*depth - t, then rounding numerators.
`default_nettype none

module dtc_proj
    import dtc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  dtc_in_t    in_data,
    input  coef_bank_t coef_bank,
    output dtc_frac_t  frac
);

    logic signed [COEF_W-1:0] coef [NUM_COEF];

    for (genvar g = 0; g < NUM_COEF_REGS; g++) begin : g_coef
        assign coef[2*g]   = coef_bank[g][COEF_W-1:0];
        assign coef[2*g+1] = coef_bank[g][CFG_W-1:COEF_W];
    end

    logic [PROJ_STAGES-1:0] vld_reg;
    logic [PROJ_STAGES-1:0] bad_reg;
    logic                   bad_next;

    logic [COL_W-1:0]   p1_col_reg;
    logic [ROW_W-1:0]   p1_row_reg;
    logic [DEPTH_W-1:0] p1_d_reg;
    logic [DEPTH_W-1:0] p2_d_reg;
    logic [DEPTH_W-1:0] p3_d_reg;

    logic signed [PROD_W-1:0] p2_pc_reg  [NUM_AXES];
    logic signed [PROD_W-1:0] p2_pr_reg  [NUM_AXES];
    logic signed [SUM_W-1:0]  p3_sum_reg [NUM_AXES];
    logic signed [SCL_W-1:0]  p4_scl_reg [NUM_AXES];
    logic signed [V_W-1:0]    p5_v_reg   [NUM_AXES];

    logic                    p6_valid_reg;
    logic                    p6_miss_reg;
    logic signed [NUM_W-1:0] p6_num_x_reg;
    logic signed [NUM_W-1:0] p6_num_y_reg;
    logic [MAG_W-1:0]        p6_den_reg;

    logic             p7_valid_reg;
    logic             p7_miss_reg;
    logic             p7_neg_x_reg;
    logic             p7_neg_y_reg;
    logic [MAG_W-1:0] p7_mag_x_reg;
    logic [MAG_W-1:0] p7_mag_y_reg;
    logic [MAG_W-1:0] p7_den_reg;

    // Invalid depth codes or a pixel outside the depth frame never hit.
    always_comb begin
        bad_next = (in_data.depth_mm == '0) || (in_data.depth_mm == DEPTH_INVALID)
                   || (32'(in_data.depth_col) >= DEPTH_COLS)
                   || (32'(in_data.depth_row) >= DEPTH_ROWS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            p6_valid_reg <= 1'b0;
            p7_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[PROJ_STAGES-2:0], in_valid};
            p6_valid_reg <= vld_reg[PROJ_STAGES-1];
            p7_valid_reg <= p6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bad_reg    <= {bad_reg[PROJ_STAGES-2:0], bad_next};
            p1_col_reg <= in_data.depth_col;
            p1_row_reg <= in_data.depth_row;
            p1_d_reg   <= in_data.depth_mm;
            p2_d_reg   <= p1_d_reg;
            p3_d_reg   <= p2_d_reg;
        end
    end

    // One lane per output axis: products, row sum, depth scale, translation.
    for (genvar l = 0; l < NUM_AXES; l++) begin : g_axis
        always_ff @(posedge aclk) begin
            if (en) begin
                p2_pc_reg[l]  <= PROD_W'(coef[3*l]) * PROD_W'($signed({1'b0, p1_col_reg}));
                p2_pr_reg[l]  <= PROD_W'(coef[3*l+1])
                                 * PROD_W'($signed({1'b0, p1_row_reg}));
                p3_sum_reg[l] <= SUM_W'(p2_pc_reg[l]) + SUM_W'(p2_pr_reg[l])
                                 + SUM_W'(coef[3*l+2]);
                p4_scl_reg[l] <= SCL_W'(p3_sum_reg[l]) * SCL_W'($signed({1'b0, p3_d_reg}));
                p5_v_reg[l]   <= V_W'(p4_scl_reg[l]) - V_W'(coef[COEF_T_BASE+l]);
            end
        end
    end

    // Round to nearest: x = (2*v0 + v2) / (2*v2), truncated toward zero.
    always_ff @(posedge aclk) begin
        if (en) begin
            p6_num_x_reg <= (NUM_W'(p5_v_reg[AXIS_X]) <<< 1) + NUM_W'(p5_v_reg[AXIS_Z]);
            p6_num_y_reg <= (NUM_W'(p5_v_reg[AXIS_Y]) <<< 1) + NUM_W'(p5_v_reg[AXIS_Z]);
            p6_den_reg   <= MAG_W'(p5_v_reg[AXIS_Z]) << 1;
            p6_miss_reg  <= bad_reg[PROJ_STAGES-1] || p5_v_reg[AXIS_Z][V_W-1]
                            || (p5_v_reg[AXIS_Z] == '0);

            p7_neg_x_reg <= p6_num_x_reg[NUM_W-1];
            p7_neg_y_reg <= p6_num_y_reg[NUM_W-1];
            p7_mag_x_reg <= MAG_W'(p6_num_x_reg[NUM_W-1] ? -p6_num_x_reg : p6_num_x_reg);
            p7_mag_y_reg <= MAG_W'(p6_num_y_reg[NUM_W-1] ? -p6_num_y_reg : p6_num_y_reg);
            p7_den_reg   <= p6_den_reg;
            p7_miss_reg  <= p6_miss_reg;
        end
    end

    always_comb begin
        frac.valid = p7_valid_reg;
        frac.miss  = p7_miss_reg;
        frac.neg_x = p7_neg_x_reg;
        frac.mag_x = p7_mag_x_reg;
        frac.neg_y = p7_neg_y_reg;
        frac.mag_y = p7_mag_y_reg;
        frac.den   = p7_den_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/core/dtc_div.sv -----
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
`default_nettype none

module dtc_div
    import dtc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  dtc_frac_t frac,
    output dtc_quot_t quot
);

    typedef struct packed {
        logic              miss;
        logic              neg_x;
        logic              ovf_x;
        logic [MAG_W-1:0]  rx;
        logic [QUOT_W-1:0] qx;
        logic              neg_y;
        logic              ovf_y;
        logic [MAG_W-1:0]  ry;
        logic [QUOT_W-1:0] qy;
        logic [MAG_W-1:0]  den;
    } div_stage_t;

    logic [QUOT_W:0] vld_reg;
    div_stage_t      st_reg [QUOT_W+1];
    div_stage_t      st0_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QUOT_W-1:0], frac.valid};
        end
    end

    // A quotient wider than QUOT_W bits can never land inside the frame.
    always_comb begin
        st0_next.miss  = frac.miss;
        st0_next.neg_x = frac.neg_x;
        st0_next.ovf_x = (frac.mag_x >> QUOT_W) >= frac.den;
        st0_next.rx    = frac.mag_x;
        st0_next.qx    = '0;
        st0_next.neg_y = frac.neg_y;
        st0_next.ovf_y = (frac.mag_y >> QUOT_W) >= frac.den;
        st0_next.ry    = frac.mag_y;
        st0_next.qy    = '0;
        st0_next.den   = frac.den;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= st0_next;
        end
    end

    for (genvar j = 1; j <= QUOT_W; j++) begin : g_step
        localparam int unsigned K = QUOT_W - j;

        div_stage_t st_next;
        logic       ge_x;
        logic       ge_y;

        always_comb begin
            st_next = st_reg[j-1];
            ge_x    = (st_reg[j-1].rx >> K) >= st_reg[j-1].den;
            ge_y    = (st_reg[j-1].ry >> K) >= st_reg[j-1].den;
            if (ge_x) begin
                st_next.rx = st_reg[j-1].rx - (st_reg[j-1].den << K);
            end
            if (ge_y) begin
                st_next.ry = st_reg[j-1].ry - (st_reg[j-1].den << K);
            end
            st_next.qx[K] = ge_x;
            st_next.qy[K] = ge_y;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j] <= st_next;
            end
        end
    end

    always_comb begin
        quot.valid = vld_reg[QUOT_W];
        quot.miss  = st_reg[QUOT_W].miss;
        quot.neg_x = st_reg[QUOT_W].neg_x;
        quot.ovf_x = st_reg[QUOT_W].ovf_x;
        quot.qx    = st_reg[QUOT_W].qx;
        quot.neg_y = st_reg[QUOT_W].neg_y;
        quot.ovf_y = st_reg[QUOT_W].ovf_y;
        quot.qy    = st_reg[QUOT_W].qy;
    end

endmodule

`default_nettype wire

// ----- rtl/core/dtc_out.sv -----
// Frame bounds check, linear index and output register.
`default_nettype none

module dtc_out
    import dtc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  dtc_quot_t          quot,
    input  logic [COORD_W-1:0] color_width,
    input  logic [COORD_W-1:0] color_height,
    output logic               out_valid,
    output dtc_out_t           out_data
);

    logic x_ok;
    logic y_ok;
    logic hit_next;

    logic               h_valid_reg;
    logic               h_hit_reg;
    logic [COORD_W-1:0] h_x_reg;
    logic [COORD_W-1:0] h_y_reg;
    logic [INDEX_W-1:0] h_prod_reg;

    logic     o_valid_reg;
    dtc_out_t o_data_reg;
    dtc_out_t o_data_next;

    // A negative numerator hits only when its quotient truncates to zero.
    always_comb begin
        x_ok = !quot.ovf_x && !(quot.neg_x && (quot.qx != '0)) && (quot.qx < color_width);
        y_ok = !quot.ovf_y && !(quot.neg_y && (quot.qy != '0)) && (quot.qy < color_height);
        hit_next = !quot.miss && x_ok && y_ok;
    end

    always_comb begin
        o_data_next = '0;
        if (h_hit_reg) begin
            o_data_next.hit         = 1'b1;
            o_data_next.color_x     = h_x_reg;
            o_data_next.color_y     = h_y_reg;
            o_data_next.color_index = h_prod_reg + INDEX_W'(h_x_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (en) begin
            h_valid_reg <= quot.valid;
            o_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_hit_reg  <= hit_next;
            h_x_reg    <= quot.qx;
            h_y_reg    <= quot.qy;
            h_prod_reg <= INDEX_W'(quot.qy) * INDEX_W'(color_width);
            o_data_reg <= o_data_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/depth_to_color_pixel_projection.sv -----
// Depth-to-color pixel projection: maps one depth pixel to a color frame coordinate.
`default_nettype none

// Each accepted item (depth column, row and depth in mm) is projected as
// v = M*[col,row,1]*depth - t with the Q18.14 matrix and translation held in
// registers 0..5, and the color coordinate is round(v0/v2), round(v1/v2) with
// halves rounded up and the result truncated toward zero. hit is set when the
// pixel lies inside the depth frame, the depth is neither 0 nor 65535, v2 > 0
// and the point falls inside color_width x color_height; on a miss every
// result field is zero. Rate: one item per clock unless a result waits at the
// output. The pipeline has 7 projection stages, a 13-stage divider (overflow
// check plus one quotient bit per stage for the 12-bit coordinate) and 2 stages
// of bounds check, index multiply and output register. The whole pipeline
// advances on one enable, which is low only while a result waits at the
// output, so s_ready follows m_ready whenever m_valid is high.
// Registers are written through cfg_wr_en/cfg_index/cfg_data at any edge;
// they are read live by the pipeline, so write them only while it is empty.

module depth_to_color_pixel_projection
    import dtc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    // Depth pixel items in
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dtc_in_t              s_data,

    // Color coordinate items out
    output logic                 m_valid,
    input  logic                 m_ready,
    output dtc_out_t             m_data
);

    coef_bank_t         coef_bank_reg;
    logic [COORD_W-1:0] width_reg;
    logic [COORD_W-1:0] height_reg;

    logic      pipe_en;
    dtc_frac_t frac;
    dtc_quot_t quot;

    // Configuration registers; coefficients reset to zero, frame to 1920x1080.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_bank_reg <= '0;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_M00_M01:      coef_bank_reg[0] <= cfg_data;
                REG_M02_M10:      coef_bank_reg[1] <= cfg_data;
                REG_M11_M12:      coef_bank_reg[2] <= cfg_data;
                REG_M20_M21:      coef_bank_reg[3] <= cfg_data;
                REG_M22_T0:       coef_bank_reg[4] <= cfg_data;
                REG_T1_T2:        coef_bank_reg[5] <= cfg_data;
                REG_COLOR_WIDTH:  width_reg        <= cfg_data[COORD_W-1:0];
                REG_COLOR_HEIGHT: height_reg       <= cfg_data[COORD_W-1:0];
            endcase
        end
    end

    // Global stall: everything moves unless the output register is held.
    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;

    dtc_proj u_proj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .coef_bank (coef_bank_reg),
        .frac      (frac)
    );

    dtc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .frac    (frac),
        .quot    (quot)
    );

    dtc_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (pipe_en),
        .quot         (quot),
        .color_width  (width_reg),
        .color_height (height_reg),
        .out_valid    (m_valid),
        .out_data     (m_data)
    );

endmodule

`default_nettype wire

// ----- rtl/core/dtc_checker.sv -----
// Port-level assertions for the depth-to-color projection, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module dtc_checker
    import dtc_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input dtc_out_t m_data
);

    // No result survives reset.
    `DTC_ASSERT_NR(a_reset_idle, aclk, !aresetn |=> !m_valid)

    // A stalled result stays put.
    `DTC_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))

    // Misses carry all-zero coordinates and index.
    `DTC_ASSERT(a_miss_zero, aclk, aresetn, (m_valid && !m_data.hit) |-> (m_data == '0))

    // Input side is never blocked while the output register is free.
    `DTC_ASSERT(a_ready_free, aclk, aresetn, (!m_valid || m_ready) |-> s_ready)

endmodule

bind depth_to_color_pixel_projection dtc_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
